// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent, checked at the same edge
`define ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error(msg);

`endif

// File: hw/rtl/crtc_pkg.sv
// ----------------------------------------------------------------------------
// crtc_pkg
// Types, port codes, register indexes and the BCD helper for the RTC file.
// ----------------------------------------------------------------------------
`default_nettype none

package crtc_pkg;

	// bus operation codes
	localparam logic [1:0] OP_RD_DATA  = 2'd0;
	localparam logic [1:0] OP_WR_INDEX = 2'd1;
	localparam logic [1:0] OP_WR_DATA  = 2'd2;
	localparam logic [1:0] OP_RD_INDEX = 2'd3;

	// register indexes
	localparam logic [6:0] IDX_SECONDS  = 7'h00;
	localparam logic [6:0] IDX_MINUTES  = 7'h02;
	localparam logic [6:0] IDX_HOURS    = 7'h04;
	localparam logic [6:0] IDX_WEEKDAY  = 7'h06;
	localparam logic [6:0] IDX_DAY      = 7'h07;
	localparam logic [6:0] IDX_MONTH    = 7'h08;
	localparam logic [6:0] IDX_YEAR     = 7'h09;
	localparam logic [6:0] IDX_REG_A    = 7'h0A;
	localparam logic [6:0] IDX_REG_B    = 7'h0B;
	localparam logic [6:0] IDX_REG_C    = 7'h0C;
	localparam logic [6:0] IDX_REG_D    = 7'h0D;
	localparam logic [6:0] IDX_RAM_BASE = 7'h0E;

	localparam logic [7:0] BYTE_UNDEF  = 8'hFF;
	localparam logic [7:0] REG_D_VALUE = 8'h80;
	localparam logic [7:0] REG_A_MASK  = 8'h7F;

	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] write_value;
		logic [5:0] now_seconds;
		logic [5:0] now_minutes;
		logic [4:0] now_hours;
		logic [2:0] now_weekday;
		logic [4:0] now_day;
		logic [3:0] now_month;
		logic [6:0] now_year;
	} crtc_cmd_t;

	typedef struct packed {
		logic [7:0] read_byte;
		logic       nmi_enabled;
	} crtc_result_t;

	// binary to packed BCD; tens = v/10 via reciprocal 205/2048 (exact for v < 128)
	function automatic logic [7:0] bin_to_bcd(input logic [6:0] v);
		logic [14:0] prod;
		logic [3:0]  tens;
		logic [6:0]  ones;
		prod = 15'(v) * 15'd205;
		tens = prod[14:11];
		ones = v - 7'(7'(tens) * 7'd10);
		return {tens, ones[3:0]};
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/cmos_rtc_register_file_top.sv
// ----------------------------------------------------------------------------
// cmos_rtc_register_file_top
// Index/data port RTC with BCD time readout and CMOS RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: a beat is taken at a clock edge with start high and busy
//   low. busy is held low, so one access may be issued every cycle.
//   cmd.opcode selects data read, index write, data write or index read.
//   Result channel: every command yields one result beat, shown on result for
//   one cycle with done high. The receiver cannot stall; a result is lost if
//   not captured in that cycle.
//   A command passes through the input register, the RAM read register and
//   the result register before its result is on the ports. Throughput is
//   one command per cycle; the single-port RAM is read and written in the
//   same stage, so back-to-back accesses see each other in order.
//   read_byte is the data read, 0xFF for writes, index reads and undecoded
//   indexes. nmi_enabled is the NMI enable after this access.
//   Reset (arst_n low) clears the index, the NMI enable and the pipeline;
//   RAM entries read as zero until written (per-entry valid bits, no sweep).
//   Indexes at or above RAM_DEPTH ignore writes and read 0xFF.
// ----------------------------------------------------------------------------
`default_nettype none

module cmos_rtc_register_file_top #(
	parameter int RAM_DEPTH = 128
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output      logic                  busy,
	input  wire crtc_pkg::crtc_cmd_t   cmd,
	output      logic                  done,
	output      crtc_pkg::crtc_result_t result
);

	import crtc_pkg::*;

	localparam int         RAM_AW    = $clog2(RAM_DEPTH);
	localparam logic [8:0] DEPTH_LIM = 9'(RAM_DEPTH);

	// stage 1: registered command
	logic       valid_s1;
	crtc_cmd_t  cmd_s1;

	// architectural state
	logic [6:0] index_q;
	logic       nmi_q;

	// stage 2: decoded read
	logic       valid_s2;
	logic       sel_ram_s2;
	logic       mask_s2;
	logic [7:0] byte_s2;
	logic       nmi_s2;

	// result register
	logic         done_q;
	crtc_result_t result_q;

	// stage 1 decode
	logic [7:0]        idx_ext;
	logic              in_range;
	logic [RAM_AW-1:0] ram_addr;
	logic              ram_we;
	logic [7:0]        ram_rdata;
	logic              sel_ram;
	logic              mask_a;
	logic [7:0]        byte_val;
	logic              nmi_next;
	logic              is_rd;

	assign busy = 1'b0;

	assign idx_ext  = {1'b0, index_q};
	assign in_range = {1'b0, idx_ext} < DEPTH_LIM;
	assign ram_addr = idx_ext[RAM_AW-1:0];
	assign ram_we   = valid_s1 && (cmd_s1.opcode == OP_WR_DATA) && in_range;
	assign is_rd    = cmd_s1.opcode == OP_RD_DATA;

	always_comb begin
		nmi_next = nmi_q;
		if (valid_s1 && (cmd_s1.opcode == OP_WR_INDEX)) begin
			nmi_next = ~cmd_s1.write_value[7];
		end
	end

	// read mux select: time fields in BCD, fixed bytes, or RAM
	always_comb begin
		sel_ram  = 1'b0;
		mask_a   = 1'b0;
		byte_val = BYTE_UNDEF;
		if (index_q >= IDX_RAM_BASE) begin
			sel_ram = in_range;
		end else begin
			case (index_q)
				IDX_SECONDS: byte_val = bin_to_bcd(7'(cmd_s1.now_seconds));
				IDX_MINUTES: byte_val = bin_to_bcd(7'(cmd_s1.now_minutes));
				IDX_HOURS:   byte_val = bin_to_bcd(7'(cmd_s1.now_hours));
				IDX_WEEKDAY: byte_val = bin_to_bcd(7'(cmd_s1.now_weekday) + 7'd1);
				IDX_DAY:     byte_val = bin_to_bcd(7'(cmd_s1.now_day));
				IDX_MONTH:   byte_val = bin_to_bcd(7'(cmd_s1.now_month));
				IDX_YEAR:    byte_val = bin_to_bcd(cmd_s1.now_year);
				IDX_REG_A: begin
					sel_ram = in_range;
					mask_a  = 1'b1;
				end
				IDX_REG_B:   sel_ram = in_range;
				IDX_REG_C:   sel_ram = in_range;
				IDX_REG_D:   byte_val = REG_D_VALUE;
				default:     byte_val = BYTE_UNDEF;
			endcase
		end
		// non-read operations always return 0xFF
		if (!is_rd) begin
			sel_ram  = 1'b0;
			byte_val = BYTE_UNDEF;
		end
	end

	crtc_ram #(
		.DEPTH (RAM_DEPTH)
	) u_ram (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (ram_we),
		.addr   (ram_addr),
		.wdata  (cmd_s1.write_value),
		.rdata  (ram_rdata)
	);

	// payload registers
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			cmd_s1 <= cmd;
		end
		sel_ram_s2 <= sel_ram;
		mask_s2    <= mask_a;
		byte_s2    <= byte_val;
		nmi_s2     <= nmi_next;
		if (valid_s2) begin
			if (sel_ram_s2) begin
				result_q.read_byte <= mask_s2 ? (ram_rdata & REG_A_MASK) : ram_rdata;
			end else begin
				result_q.read_byte <= byte_s2;
			end
			result_q.nmi_enabled <= nmi_s2;
		end
	end

	// control and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			done_q   <= 1'b0;
			index_q  <= '0;
			nmi_q    <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
			done_q   <= valid_s2;
			nmi_q    <= nmi_next;
			if (valid_s1 && (cmd_s1.opcode == OP_WR_INDEX)) begin
				index_q <= cmd_s1.write_value[6:0];
			end
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

`default_nettype wire

// File: hw/rtl/crtc_ram.sv
// ----------------------------------------------------------------------------
// crtc_ram
// CMOS byte store with per-entry valid bits; unwritten entries read as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module crtc_ram #(
	parameter int DEPTH = 128
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [7:0]               wdata,
	output      logic [7:0]               rdata
);

	logic [7:0]       mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [7:0]       data_q;
	logic             hit_q;

	// storage, no reset
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		data_q <= mem[addr];
	end

	// valid bits stand in for the reset clear
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			hit_q <= 1'b0;
		end else begin
			if (we) begin
				vld_q[addr] <= 1'b1;
			end
			hit_q <= vld_q[addr];
		end
	end

	assign rdata = hit_q ? data_q : 8'h00;

endmodule

`default_nettype wire

// File: hw/rtl/crtc_checker.sv
// ----------------------------------------------------------------------------
// crtc_checker
// Port-level checks on the RTC register file, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module crtc_checker (
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   start,
	input wire logic                   busy,
	input wire crtc_pkg::crtc_cmd_t    cmd,
	input wire logic                   done,
	input wire crtc_pkg::crtc_result_t result
);

	import crtc_pkg::*;

	logic take;
	logic take_nrd;
	logic take_idx;
	logic nmi_bit;

	assign take     = start && !busy;
	assign take_nrd = take && (cmd.opcode != OP_RD_DATA);
	assign take_idx = take && (cmd.opcode == OP_WR_INDEX);
	assign nmi_bit  = !cmd.write_value[7];

	`ASSERT_IMPL(a_result_follows, take, ##3 done, "command beat without result beat")
	`ASSERT_IMPL(a_no_spurious, !take, ##3 !done, "result beat without command beat")
	`ASSERT_IMPL(a_write_ff, take_nrd, ##3 (result.read_byte == BYTE_UNDEF), "data on non read")
	`ASSERT_IMPL(a_nmi_follow, take_idx, ##3 (result.nmi_enabled == $past(nmi_bit, 3)), "bad NMI")

endmodule

bind cmos_rtc_register_file_top crtc_checker u_crtc_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.cmd    (cmd),
	.done   (done),
	.result (result)
);

`default_nettype wire

// File: tb/cmos_rtc_register_file_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmos_rtc_register_file_top_tb
// Self-checking bench for the index/data port RTC and CMOS RAM.
// A directed set covers the clock fields in BCD, register A masking, register
// D, an alarm slot, NMI enable and the top RAM byte; then about a thousand
// random bus accesses run, mostly index-then-data sequences. Every command
// beat updates a local model of the index, NMI flag and RAM, and every result
// beat is compared with the oldest predicted one.
// ----------------------------------------------------------------------------

module cmos_rtc_register_file_top_tb;

	import crtc_pkg::*;

	localparam int RAM_SIZE  = 128;
	localparam int RUN_LIMIT = 200000;
	localparam int RANDOM_ACCESSES = 1000;

	// alarm slots are not decoded and read as 0xFF
	localparam logic [6:0] IDX_ALARM_SEC  = 7'h01;
	localparam logic [6:0] IDX_ALARM_MIN  = 7'h03;
	localparam logic [6:0] IDX_ALARM_HOUR = 7'h05;
	localparam logic [6:0] IDX_RAM_TOP    = 7'h7F;
	localparam logic [7:0] NMI_OFF        = 8'h80;

	// one queued bus access; hold_off makes the driver wait for an empty pipe
	typedef struct {
		crtc_cmd_t cmd;
		bit        hold_off;
	} bus_access_t;

	logic         clk;
	logic         arst_n;
	logic         start = 1'b0;
	crtc_cmd_t    cmd   = '0;
	logic         busy;
	logic         done;
	crtc_result_t result;

	cmos_rtc_register_file_top #(
		.RAM_DEPTH(RAM_SIZE)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.result (result)
	);

	// ------------------------------------------------------------------------
	// Model of the register file: index latch, NMI enable and RAM contents
	// ------------------------------------------------------------------------
	logic [6:0] index_q = '0;
	logic       nmi_q   = 1'b0;
	logic [7:0] cmos_bytes [RAM_SIZE];

	bus_access_t  bus_accesses[$];
	crtc_result_t expected_results[$];

	int  miss_count  = 0;
	int  cycle_count = 0;
	int  gap_left    = 0;
	bit  took_beat   = 1'b0;
	bit  steady      = 1'b0;

	// packed BCD, tens digit may run past 9 for out-of-range inputs
	function automatic logic [7:0] to_bcd(int unsigned v);
		int unsigned tens;
		int unsigned ones;
		tens = v / 10;
		ones = v % 10;
		return 8'((tens << 4) | ones);
	endfunction

	function automatic logic [7:0] ram_byte(logic [6:0] a);
		if (int'(a) < RAM_SIZE) begin
			return cmos_bytes[a];
		end
		return BYTE_UNDEF;
	endfunction

	function automatic logic [7:0] data_port_byte(crtc_cmd_t c);
		if (index_q >= IDX_RAM_BASE) begin
			return ram_byte(index_q);
		end
		case (index_q)
			IDX_SECONDS: return to_bcd(c.now_seconds);
			IDX_MINUTES: return to_bcd(c.now_minutes);
			IDX_HOURS:   return to_bcd(c.now_hours);
			// weekday register reads the weekday input plus one, 1..8
			IDX_WEEKDAY: return to_bcd(int'(c.now_weekday) + 1);
			IDX_DAY:     return to_bcd(c.now_day);
			IDX_MONTH:   return to_bcd(c.now_month);
			IDX_YEAR:    return to_bcd(c.now_year);
			IDX_REG_A:   return ram_byte(index_q) & REG_A_MASK;
			IDX_REG_B:   return ram_byte(index_q);
			IDX_REG_C:   return ram_byte(index_q);
			IDX_REG_D:   return REG_D_VALUE;
			default:     return BYTE_UNDEF;
		endcase
	endfunction

	// apply one access to the model and return the result it should produce
	function automatic crtc_result_t rtc_access(crtc_cmd_t c);
		crtc_result_t r;
		r.read_byte = BYTE_UNDEF;
		case (c.opcode)
			OP_RD_DATA: begin
				r.read_byte = data_port_byte(c);
			end
			OP_WR_INDEX: begin
				index_q = c.write_value[6:0];
				nmi_q   = ~c.write_value[7];
			end
			OP_WR_DATA: begin
				if (int'(index_q) < RAM_SIZE) begin
					cmos_bytes[index_q] = c.write_value;
				end
			end
			default: begin
			end
		endcase
		r.nmi_enabled = nmi_q;
		return r;
	endfunction

	// random clock inputs: mostly in range, sometimes any value the field holds
	function automatic crtc_cmd_t make_access(logic [1:0] op, logic [7:0] value);
		crtc_cmd_t c;
		bit        wild;
		wild          = ($urandom_range(0, 3) == 0);
		c.opcode      = op;
		c.write_value = value;
		c.now_seconds = wild ? 6'($urandom) : 6'($urandom_range(0, 59));
		c.now_minutes = wild ? 6'($urandom) : 6'($urandom_range(0, 59));
		c.now_hours   = wild ? 5'($urandom) : 5'($urandom_range(0, 23));
		c.now_weekday = wild ? 3'($urandom) : 3'($urandom_range(0, 6));
		c.now_day     = wild ? 5'($urandom) : 5'($urandom_range(1, 31));
		c.now_month   = wild ? 4'($urandom) : 4'($urandom_range(1, 12));
		c.now_year    = wild ? 7'($urandom) : 7'($urandom_range(0, 99));
		return c;
	endfunction

	task automatic queue_access(logic [1:0] op, logic [7:0] value, bit hold_off = 1'b0);
		bus_access_t a;
		a.cmd      = make_access(op, value);
		a.hold_off = hold_off;
		bus_accesses.push_back(a);
	endtask

	// clock read with every time input at all zeros or all ones
	task automatic queue_clock_read(bit ones);
		bus_access_t a;
		a.cmd          = make_access(OP_RD_DATA, 8'($urandom));
		a.cmd.now_seconds = ones ? '1 : '0;
		a.cmd.now_minutes = ones ? '1 : '0;
		a.cmd.now_hours   = ones ? '1 : '0;
		a.cmd.now_weekday = ones ? '1 : '0;
		a.cmd.now_day     = ones ? '1 : '0;
		a.cmd.now_month   = ones ? '1 : '0;
		a.cmd.now_year    = ones ? '1 : '0;
		a.hold_off     = 1'b0;
		bus_accesses.push_back(a);
	endtask

	task automatic report_miss(string what, int want, int got);
		miss_count++;
		if (miss_count <= 10) begin
			$display("[%0t] %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
		end
	endtask

	// ------------------------------------------------------------------------
	// Clock and reset
	// ------------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Driver: launches queued accesses at the falling edge, holds a beat until
	// it is taken, then idles for a random gap. Steady stretches run gap-free.
	// ------------------------------------------------------------------------
	always @(negedge clk) begin : drive
		bus_access_t a;
		crtc_cmd_t   next_cmd;
		logic        next_start;
		int          r;
		if (arst_n) begin
			next_cmd   = cmd;
			next_start = start;
			if (start && took_beat) begin
				next_start = 1'b0;
			end
			if (!next_start) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (bus_accesses.size() != 0 &&
						!(bus_accesses[0].hold_off && expected_results.size() != 0)) begin
					a          = bus_accesses.pop_front();
					next_cmd   = a.cmd;
					next_start = 1'b1;
					if ($urandom_range(0, 39) == 0) begin
						steady = ~steady;
					end
					r = $urandom_range(0, 99);
					if (steady || r < 60) begin
						gap_left = 0;
					end else if (r < 92) begin
						gap_left = $urandom_range(1, 3);
					end else begin
						gap_left = $urandom_range(8, 30);
					end
				end
			end
			// one nonblocking write per signal per edge
			start <= next_start;
			cmd   <= next_cmd;
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: at the rising edge, check a result beat against the oldest
	// prediction, then predict for a command beat taken at this edge.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : observe
		crtc_result_t want;
		if (arst_n) begin
			if (done) begin
				if (expected_results.size() == 0) begin
					report_miss("result beat with nothing pending", 0, result);
				end else begin
					want = expected_results.pop_front();
					if (result.read_byte !== want.read_byte) begin
						report_miss("read_byte", want.read_byte, result.read_byte);
					end
					if (result.nmi_enabled !== want.nmi_enabled) begin
						report_miss("nmi_enabled", want.nmi_enabled, result.nmi_enabled);
					end
				end
			end
			took_beat = (start === 1'b1) && (busy === 1'b0);
			if (took_beat) begin
				expected_results.push_back(rtc_access(cmd));
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == RUN_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus and end of run
	// ------------------------------------------------------------------------
	initial begin : stimulus
		logic [6:0] pick;
		logic [6:0] clock_fields [6];
		int         n;
		int         burst;
		logic [1:0] op;
		bit         hold;
		bit         held;

		foreach (cmos_bytes[i]) begin
			cmos_bytes[i] = '0;
		end
		arst_n = 1'b0;
		held   = 1'b0;

		// directed: seconds after reset, index port read, NMI set and clear
		queue_access(OP_RD_DATA, 8'h00);
		queue_access(OP_RD_INDEX, 8'h5A);
		queue_access(OP_WR_INDEX, NMI_OFF | 8'(IDX_SECONDS));
		queue_clock_read(1'b0);
		queue_clock_read(1'b1);
		// every clock field with out-of-range inputs, NMI bit alternating
		clock_fields = '{IDX_MINUTES, IDX_HOURS, IDX_WEEKDAY, IDX_DAY, IDX_MONTH,
			IDX_YEAR};
		foreach (clock_fields[i]) begin
			queue_access(OP_WR_INDEX, (i % 2 ? NMI_OFF : 8'h00) | 8'(clock_fields[i]));
			queue_clock_read(1'b1);
		end
		// register A loses bit 7 on readback
		queue_access(OP_WR_INDEX, 8'(IDX_REG_A));
		queue_access(OP_WR_DATA, 8'hFF);
		queue_access(OP_RD_DATA, 8'h00);
		queue_access(OP_WR_INDEX, NMI_OFF | 8'(IDX_REG_D));
		queue_access(OP_RD_DATA, 8'h00);
		queue_access(OP_WR_INDEX, 8'(IDX_ALARM_HOUR));
		queue_access(OP_RD_DATA, 8'h00);
		// top RAM byte: zero before the first write, then the written value
		queue_access(OP_WR_INDEX, 8'(IDX_RAM_TOP));
		queue_access(OP_RD_DATA, 8'h00);
		queue_access(OP_WR_DATA, 8'hA5);
		queue_access(OP_RD_DATA, 8'h00);

		// random: mostly index write followed by a few data accesses
		n = 0;
		while (n < RANDOM_ACCESSES) begin
			if ($urandom_range(0, 9) < 7) begin
				case ($urandom_range(0, 3))
					0: pick = 7'($urandom_range(0, 15));
					1: pick = ($urandom_range(0, 1) != 0) ? IDX_ALARM_SEC : IDX_ALARM_MIN;
					default: pick = 7'($urandom);
				endcase
				// first index write past the midpoint waits for an empty pipe
				hold = !held && (n >= RANDOM_ACCESSES / 2);
				held = held || hold;
				queue_access(OP_WR_INDEX, {1'($urandom), pick}, hold);
				n++;
				burst = $urandom_range(1, 4);
				repeat (burst) begin
					case ($urandom_range(0, 9))
						0:       op = OP_RD_INDEX;
						1, 2, 3: op = OP_WR_DATA;
						default: op = OP_RD_DATA;
					endcase
					queue_access(op, 8'($urandom));
					n++;
				end
			end else begin
				queue_access(2'($urandom), 8'($urandom));
				n++;
			end
		end

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// drain: every beat taken and every result seen, then a few quiet edges
		while (bus_accesses.size() != 0 || start || expected_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (10) @(posedge clk);

		if (miss_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
